>>> design/srie_pkg.sv
// Shared types, constants and opcodes for the small RISC instruction executor.
package srie_pkg;

    localparam int INSTR_W    = 32;
    localparam int REG_COUNT  = 32;
    localparam int RF_AW      = $clog2(REG_COUNT);
    localparam int MEM_DEPTH  = 1024;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);
    localparam int PROG_DEPTH = 512;
    localparam int PROG_AW    = $clog2(PROG_DEPTH);
    localparam int DIV_CW     = 5;
    localparam int OUT_W      = 96;

    localparam logic [RF_AW-1:0] PC_REG    = RF_AW'(31);
    localparam logic [RF_AW-1:0] FETCH_REG = RF_AW'(30);

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_HALTED = 3'd1;
    localparam logic [2:0] ST_BADOP  = 3'd2;
    localparam logic [2:0] ST_BADPC  = 3'd3;
    localparam logic [2:0] ST_DIVZ   = 3'd4;

    typedef enum logic [7:0] {
        OP_ADD  = 8'd0,  OP_ADDC = 8'd1,  OP_MUL  = 8'd2,  OP_SUB  = 8'd3,
        OP_DIV  = 8'd4,  OP_LSH  = 8'd5,  OP_RSH  = 8'd6,  OP_AND  = 8'd7,
        OP_OR   = 8'd8,  OP_XOR  = 8'd9,  OP_LDM  = 8'd10, OP_LDC  = 8'd11,
        OP_LDMC = 8'd12, OP_STO  = 8'd13, OP_STM  = 8'd14, OP_STMC = 8'd15,
        OP_BLT  = 8'd16, OP_BNZ  = 8'd17, OP_B    = 8'd18, OP_J    = 8'd19,
        OP_JLT  = 8'd20, OP_JNZ  = 8'd21, OP_CMP  = 8'd22, OP_HALT = 8'd23
    } op_t;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_FETCH, S_RDX, S_RDY, S_RDR, S_RDP, S_CAPP,
        S_EXEC, S_DIV, S_MRD, S_WB, S_PCW, S_DONE, S_HDONE
    } state_t;

    typedef enum logic [1:0] {
        RSEL_X, RSEL_Y, RSEL_R, RSEL_P
    } rsel_t;

    typedef struct packed {
        logic              load_instr;
        logic              fetch_wr;
        logic              rf_rd;
        rsel_t             rsel;
        logic              cap_x;
        logic              cap_y;
        logic              cap_r;
        logic              cap_p;
        logic              exec;
        logic              div_step;
        logic              dm_rd;
        logic              wb;
        logic              pc_wr;
        logic              out_load;
        logic              out_halt;
        logic              clr_en;
        logic [MEM_AW-1:0] clr_addr;
    } cmd_t;

    typedef struct packed {
        logic halted;
        logic div_go;
        logic load;
        logic out_busy;
    } sts_t;

endpackage

>>> design/srie_ctrl.sv
// Sequencing state machine for the instruction executor.
module srie_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  srie_pkg::sts_t      sts,
    output srie_pkg::cmd_t      cmd
);

    srie_pkg::state_t               state_reg, state_next;
    logic [srie_pkg::MEM_AW-1:0]    cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srie_pkg::S_CLR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            srie_pkg::S_CLR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == srie_pkg::MEM_AW'(srie_pkg::MEM_DEPTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = srie_pkg::S_IDLE;
                end
            end
            srie_pkg::S_IDLE:
                if (s_tvalid)
                    state_next = sts.halted ? srie_pkg::S_HDONE : srie_pkg::S_FETCH;
            srie_pkg::S_FETCH: state_next = srie_pkg::S_RDX;
            srie_pkg::S_RDX:   state_next = srie_pkg::S_RDY;
            srie_pkg::S_RDY:   state_next = srie_pkg::S_RDR;
            srie_pkg::S_RDR:   state_next = srie_pkg::S_RDP;
            srie_pkg::S_RDP:   state_next = srie_pkg::S_CAPP;
            srie_pkg::S_CAPP:  state_next = srie_pkg::S_EXEC;
            srie_pkg::S_EXEC:
            begin
                cnt_next = '0;
                if (sts.div_go)
                    state_next = srie_pkg::S_DIV;
                else if (sts.load)
                    state_next = srie_pkg::S_MRD;
                else
                    state_next = srie_pkg::S_WB;
            end
            srie_pkg::S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[srie_pkg::DIV_CW-1:0] == '1)
                begin
                    cnt_next   = '0;
                    state_next = srie_pkg::S_WB;
                end
            end
            srie_pkg::S_MRD:   state_next = srie_pkg::S_WB;
            srie_pkg::S_WB:    state_next = srie_pkg::S_PCW;
            srie_pkg::S_PCW:   state_next = srie_pkg::S_DONE;
            srie_pkg::S_DONE, srie_pkg::S_HDONE:
                if (!sts.out_busy)
                    state_next = srie_pkg::S_IDLE;
            default:           state_next = srie_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.rsel     = srie_pkg::RSEL_X;
        cmd.clr_addr = cnt_reg;
        s_tready     = 1'b0;
        case (state_reg)
            srie_pkg::S_CLR:   cmd.clr_en = 1'b1;
            srie_pkg::S_IDLE:
            begin
                s_tready       = 1'b1;
                cmd.load_instr = s_tvalid;
            end
            srie_pkg::S_FETCH: cmd.fetch_wr = 1'b1;
            srie_pkg::S_RDX:
            begin
                cmd.rf_rd = 1'b1;
                cmd.rsel  = srie_pkg::RSEL_X;
            end
            srie_pkg::S_RDY:
            begin
                cmd.cap_x = 1'b1;
                cmd.rf_rd = 1'b1;
                cmd.rsel  = srie_pkg::RSEL_Y;
            end
            srie_pkg::S_RDR:
            begin
                cmd.cap_y = 1'b1;
                cmd.rf_rd = 1'b1;
                cmd.rsel  = srie_pkg::RSEL_R;
            end
            srie_pkg::S_RDP:
            begin
                cmd.cap_r = 1'b1;
                cmd.rf_rd = 1'b1;
                cmd.rsel  = srie_pkg::RSEL_P;
            end
            srie_pkg::S_CAPP:  cmd.cap_p = 1'b1;
            srie_pkg::S_EXEC:  cmd.exec = 1'b1;
            srie_pkg::S_DIV:   cmd.div_step = 1'b1;
            srie_pkg::S_MRD:   cmd.dm_rd = 1'b1;
            srie_pkg::S_WB:    cmd.wb = 1'b1;
            srie_pkg::S_PCW:   cmd.pc_wr = 1'b1;
            srie_pkg::S_DONE:  cmd.out_load = !sts.out_busy;
            srie_pkg::S_HDONE:
            begin
                cmd.out_load = !sts.out_busy;
                cmd.out_halt = 1'b1;
            end
            default:           cmd = '0;
        endcase
    end

endmodule

>>> design/srie_dp.sv
// Datapath: register file, data memory, ALU, divider and result register.
module srie_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [srie_pkg::INSTR_W-1:0]  instr_in,
    input  srie_pkg::cmd_t                cmd,
    output srie_pkg::sts_t                sts,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [srie_pkg::OUT_W-1:0]    out_data
);

    logic [31:0]                  rf_mem [srie_pkg::REG_COUNT];
    logic [srie_pkg::REG_COUNT-1:0] rf_valid_reg;
    logic [31:0]                  rf_rdata_reg;
    logic                         rf_rvld_reg;
    logic [31:0]                  rf_rd_val;
    logic [srie_pkg::RF_AW-1:0]   rf_raddr;
    logic                         rf_we;
    logic [srie_pkg::RF_AW-1:0]   rf_waddr;
    logic [31:0]                  rf_wdata;

    logic [31:0]                  dm_mem [srie_pkg::MEM_DEPTH];
    logic [31:0]                  dm_rdata_reg;
    logic                         dm_we;
    logic [srie_pkg::MEM_AW-1:0]  dm_waddr;
    logic [31:0]                  dm_wdata;

    logic [31:0] instr_reg, x_reg, y_reg, r_reg, pc_reg;
    logic [31:0] val_reg, md_reg, pcb_reg, pcf_reg, valf_reg;
    logic [srie_pkg::MEM_AW-1:0] ma_reg;
    logic [2:0]  status_reg, stf_reg;
    logic        rw_reg, mw_reg, adv_reg, isdiv_reg, isld_reg, neg_reg;
    logic [31:0] quo_reg, rem_reg, ub_reg;
    logic        halted_reg;
    logic        out_valid_reg;
    logic [srie_pkg::OUT_W-1:0] out_data_reg;

    logic [7:0]  op;
    logic [srie_pkg::RF_AW-1:0] ri, i1, i2;
    logic [31:0] a1s, a2s, rs;
    logic        lt;
    logic [31:0] ex_val, ex_md, ex_pcb, ex_maddr;
    logic [2:0]  ex_status;
    logic        ex_rw, ex_mw, ex_adv;
    logic [31:0] ua, ub;
    logic [32:0] rem_sh, rem_sub;
    logic [31:0] val_fin, pc_a, pc_f;
    logic [2:0]  st_f;
    logic [srie_pkg::PROG_AW-1:0] fa;

    assign op  = instr_reg[31:24];
    assign ri  = instr_reg[16 +: srie_pkg::RF_AW];
    assign i1  = instr_reg[8 +: srie_pkg::RF_AW];
    assign i2  = instr_reg[0 +: srie_pkg::RF_AW];
    assign rs  = {{24{instr_reg[23]}}, instr_reg[23:16]};
    assign a1s = {{24{instr_reg[15]}}, instr_reg[15:8]};
    assign a2s = {{24{instr_reg[7]}}, instr_reg[7:0]};
    assign lt  = $signed(x_reg) < $signed(y_reg);

    // register file: one read, one write per cycle; unwritten entries read 0
    always_comb
    begin
        case (cmd.rsel)
            srie_pkg::RSEL_X: rf_raddr = i1;
            srie_pkg::RSEL_Y: rf_raddr = i2;
            srie_pkg::RSEL_R: rf_raddr = ri;
            srie_pkg::RSEL_P: rf_raddr = srie_pkg::PC_REG;
            default:          rf_raddr = i1;
        endcase
    end

    always_comb
    begin
        rf_we    = 1'b0;
        rf_waddr = srie_pkg::FETCH_REG;
        rf_wdata = instr_reg;
        if (cmd.fetch_wr)
            rf_we = 1'b1;
        else if (cmd.wb && rw_reg)
        begin
            rf_we    = 1'b1;
            rf_waddr = ri;
            rf_wdata = val_fin;
        end
        else if (cmd.pc_wr)
        begin
            rf_we    = 1'b1;
            rf_waddr = srie_pkg::PC_REG;
            rf_wdata = pcf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf_mem[rf_waddr] <= rf_wdata;
        if (cmd.rf_rd)
            rf_rdata_reg <= rf_mem[rf_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
            rf_rvld_reg  <= 1'b0;
        end
        else
        begin
            if (rf_we)
                rf_valid_reg[rf_waddr] <= 1'b1;
            if (cmd.rf_rd)
                rf_rvld_reg <= rf_valid_reg[rf_raddr];
        end
    end

    assign rf_rd_val = rf_rvld_reg ? rf_rdata_reg : '0;

    // data memory
    always_comb
    begin
        dm_we    = 1'b0;
        dm_waddr = ma_reg;
        dm_wdata = md_reg;
        if (cmd.clr_en)
        begin
            dm_we    = 1'b1;
            dm_waddr = cmd.clr_addr;
            dm_wdata = '0;
        end
        else if (cmd.wb && mw_reg)
            dm_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (dm_we)
            dm_mem[dm_waddr] <= dm_wdata;
        if (cmd.dm_rd)
            dm_rdata_reg <= dm_mem[ma_reg];
    end

    // decode and execute
    always_comb
    begin
        ex_val    = '0;
        ex_md     = '0;
        ex_maddr  = '0;
        ex_pcb    = pc_reg;
        ex_status = srie_pkg::ST_OK;
        ex_rw     = 1'b0;
        ex_mw     = 1'b0;
        ex_adv    = 1'b1;
        case (op)
            srie_pkg::OP_ADD:  begin ex_rw = 1'b1; ex_val = x_reg + y_reg; end
            srie_pkg::OP_ADDC: begin ex_rw = 1'b1; ex_val = x_reg + a2s; end
            srie_pkg::OP_MUL:  begin ex_rw = 1'b1; ex_val = x_reg * y_reg; end
            srie_pkg::OP_SUB:  begin ex_rw = 1'b1; ex_val = x_reg - y_reg; end
            srie_pkg::OP_DIV:
                if (y_reg == '0)
                begin
                    ex_status = srie_pkg::ST_DIVZ;
                    ex_adv    = 1'b0;
                end
                else
                    ex_rw = 1'b1;
            srie_pkg::OP_LSH:  begin ex_rw = 1'b1; ex_val = x_reg << y_reg[4:0]; end
            srie_pkg::OP_RSH:
            begin
                ex_rw  = 1'b1;
                ex_val = 32'($signed(x_reg) >>> y_reg[4:0]);
            end
            srie_pkg::OP_AND:  begin ex_rw = 1'b1; ex_val = x_reg & y_reg; end
            srie_pkg::OP_OR:   begin ex_rw = 1'b1; ex_val = x_reg | y_reg; end
            srie_pkg::OP_XOR:  begin ex_rw = 1'b1; ex_val = x_reg ^ y_reg; end
            srie_pkg::OP_LDM:  begin ex_rw = 1'b1; ex_maddr = x_reg + y_reg; end
            srie_pkg::OP_LDC:  begin ex_rw = 1'b1; ex_val = a1s; end
            srie_pkg::OP_LDMC: begin ex_rw = 1'b1; ex_maddr = x_reg + a2s; end
            srie_pkg::OP_STO:
            begin
                ex_mw = 1'b1; ex_maddr = a1s + a2s; ex_md = rs;
            end
            srie_pkg::OP_STM:
            begin
                ex_mw = 1'b1; ex_maddr = x_reg + y_reg; ex_md = r_reg;
            end
            srie_pkg::OP_STMC:
            begin
                ex_mw = 1'b1; ex_maddr = x_reg + a2s; ex_md = r_reg;
            end
            srie_pkg::OP_BLT:
                if (lt)
                begin
                    ex_pcb = r_reg; ex_adv = 1'b0;
                end
            srie_pkg::OP_BNZ:
                if (instr_reg[15:8] != 8'd0)
                begin
                    ex_pcb = r_reg; ex_adv = 1'b0;
                end
            srie_pkg::OP_B:    begin ex_pcb = r_reg; ex_adv = 1'b0; end
            srie_pkg::OP_J:    begin ex_pcb = pc_reg + rs; ex_adv = 1'b0; end
            srie_pkg::OP_JLT:
                if (lt)
                begin
                    ex_pcb = pc_reg + rs; ex_adv = 1'b0;
                end
            srie_pkg::OP_JNZ:
                if (instr_reg[15:8] != 8'd0)
                begin
                    ex_pcb = pc_reg + rs; ex_adv = 1'b0;
                end
            srie_pkg::OP_CMP:
            begin
                ex_rw  = 1'b1;
                ex_val = lt ? '1 : ((x_reg == y_reg) ? 32'd0 : 32'd1);
            end
            srie_pkg::OP_HALT:
            begin
                ex_status = srie_pkg::ST_HALTED; ex_adv = 1'b0;
            end
            default:
            begin
                ex_status = srie_pkg::ST_BADOP; ex_adv = 1'b0;
            end
        endcase
    end

    assign ua      = x_reg[31] ? 32'd0 - x_reg : x_reg;
    assign ub      = y_reg[31] ? 32'd0 - y_reg : y_reg;
    assign rem_sh  = {rem_reg, quo_reg[31]};
    assign rem_sub = rem_sh - {1'b0, ub_reg};

    assign sts.div_go   = (op == srie_pkg::OP_DIV) && (y_reg != '0);
    assign sts.load     = (op == srie_pkg::OP_LDM) || (op == srie_pkg::OP_LDMC);
    assign sts.halted   = halted_reg;
    assign sts.out_busy = out_valid_reg && !out_ready;

    // write-back: final value, counter and status
    always_comb
    begin
        if (isld_reg)
            val_fin = dm_rdata_reg;
        else if (isdiv_reg)
            val_fin = neg_reg ? 32'd0 - quo_reg : quo_reg;
        else
            val_fin = val_reg;
        pc_a = (rw_reg && ri == srie_pkg::PC_REG) ? val_fin : pcb_reg;
        pc_f = adv_reg ? pc_a + 32'd1 : pc_a;
        st_f = status_reg;
        if (status_reg == srie_pkg::ST_OK && pc_f >= 32'(srie_pkg::PROG_DEPTH))
            st_f = srie_pkg::ST_BADPC;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_instr)
            instr_reg <= instr_in;
        if (cmd.cap_x)
            x_reg <= rf_rd_val;
        if (cmd.cap_y)
            y_reg <= rf_rd_val;
        if (cmd.cap_r)
            r_reg <= rf_rd_val;
        if (cmd.cap_p)
            pc_reg <= rf_rd_val;
        if (cmd.exec)
        begin
            val_reg    <= ex_val;
            md_reg     <= ex_md;
            ma_reg     <= ex_maddr[srie_pkg::MEM_AW-1:0];
            pcb_reg    <= ex_pcb;
            status_reg <= ex_status;
            rw_reg     <= ex_rw;
            mw_reg     <= ex_mw;
            adv_reg    <= ex_adv;
            isdiv_reg  <= sts.div_go;
            isld_reg   <= sts.load;
            neg_reg    <= x_reg[31] ^ y_reg[31];
            quo_reg    <= ua;
            rem_reg    <= '0;
            ub_reg     <= ub;
        end
        if (cmd.div_step)
        begin
            // restoring divide, one quotient bit per cycle
            if (!rem_sub[32])
            begin
                rem_reg <= rem_sub[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (cmd.wb)
        begin
            pcf_reg  <= pc_f;
            stf_reg  <= st_f;
            valf_reg <= val_fin;
        end
    end

    assign fa = (stf_reg == srie_pkg::ST_OK) ? pcf_reg[srie_pkg::PROG_AW-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.out_halt)
                out_data_reg <= {{(srie_pkg::OUT_W-3){1'b0}}, srie_pkg::ST_HALTED};
            else
                out_data_reg <= {3'b000,
                                 mw_reg ? md_reg : 32'd0,
                                 mw_reg ? ma_reg : {srie_pkg::MEM_AW{1'b0}},
                                 mw_reg,
                                 rw_reg ? valf_reg : 32'd0,
                                 rw_reg ? ri : {srie_pkg::RF_AW{1'b0}},
                                 rw_reg,
                                 fa,
                                 stf_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wb && st_f != srie_pkg::ST_OK)
                halted_reg <= 1'b1;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> design/small_risc_instruction_executor_core.sv
// Top level of the small RISC instruction executor.
//
// Slave channel: one beat per 32-bit instruction word, taken from the address
// reported in the previous result (0 after reset). Master channel: one result
// beat per instruction (status, next fetch address, register and store info).
// After reset the data memory is cleared while s_tready is held low.
// Loads add a data memory read before write-back; divides go through a
// 32-step iterative divider; once halted, a beat skips execution. One
// instruction is worked on at a time; the next beat is taken once the result
// sits in the output register. If the receiver stalls, the finished result
// holds and the next instruction runs up to its result, then waits for the
// register to free.
// Halt, bad opcode, bad counter or divide by zero stop execution: every later
// beat gets status 1 until reset.
module small_risc_instruction_executor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // instr_word
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], fetch_addr[11:3], reg_write[12], dest_reg[17:13],
    // dest_value[49:18], mem_write[50], mem_addr[60:51], mem_data[92:61]
    output logic [95:0] m_tdata
);

    srie_pkg::cmd_t cmd;
    srie_pkg::sts_t sts;

    srie_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    srie_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .instr_in  (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

`ifndef SYNTHESIS
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= srie_pkg::ST_DIVZ)
        else $error("status code out of range");

    a_fetch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2:0] != srie_pkg::ST_OK) |-> m_tdata[11:3] == 9'd0)
        else $error("fetch address nonzero on stop");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[12] && m_tdata[50]))
        else $error("register and memory write in one beat");
`endif

endmodule
